>>> src/fprp_pkg.sv
`timescale 1ns / 1ps

package fprp_pkg;

    // Control characters and delimiters of the control stream
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Reply codes and limits
    localparam int unsigned CODE_W    = 10;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PORT_W    = 16;
    localparam logic [CODE_W-1:0] CODE_MAX       = 10'd999;
    localparam logic [CODE_W-1:0] CODE_FILE_ERR  = 10'd550;
    localparam logic [CODE_W-1:0] CODE_LOGIN_ERR = 10'd530;

    // Passive tuple: six fields, each saturating one above a byte
    localparam int unsigned NUM_FIELDS = 6;
    localparam logic [2:0]  LAST_FIELD = 3'd5;
    localparam logic [2:0]  ALL_FIELDS = 3'd6;
    localparam logic [8:0]  FIELD_SAT  = 9'd256;

    // Line position: fourth character decides the final line
    localparam logic [2:0] POS_FINAL = 3'd3;
    localparam logic [2:0] POS_SAT   = 3'd4;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 64;

    typedef struct packed {
        logic [PORT_W-1:0] data_port;
        logic [ADDR_W-1:0] server_address;
        logic              tuple_valid;
        logic              command_error;
        logic [CODE_W-1:0] reply_code;
    } t_result;

endpackage

>>> src/fprp_in_reg.sv
`timescale 1ns / 1ps

module fprp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Accept when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the byte on each transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> src/fprp_line_state.sv
`timescale 1ns / 1ps

module fprp_line_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_slot_free,
    output logic             o_take,
    output logic             o_load,
    output fprp_pkg::t_result o_result
);

    logic [2:0] r_pos,       n_pos;
    logic       r_final,     n_final;
    logic [9:0] r_code,      n_code;
    logic       r_code_done, n_code_done;
    logic       r_inside,    n_inside;
    logic [2:0] r_idx,       n_idx;
    logic [8:0] r_facc,      n_facc;
    logic [7:0] r_fields [fprp_pkg::NUM_FIELDS];
    logic [7:0] n_fields [fprp_pkg::NUM_FIELDS];
    logic       r_ovf,       n_ovf;

    logic        is_lf;
    logic        is_cr;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [13:0] code_prod;
    logic [11:0] facc_prod;
    logic        do_complete;
    logic        close_last;
    logic [7:0]  last_field;
    logic        ovf_end;
    logic        tuple_ok;
    logic        is_result;

    // Classify the byte
    assign is_lf     = (i_byte == fprp_pkg::CHAR_LF);
    assign is_cr     = (i_byte == fprp_pkg::CHAR_CR);
    assign is_digit  = (i_byte >= fprp_pkg::CHAR_ZERO) && (i_byte <= fprp_pkg::CHAR_NINE);
    assign digit_val = i_byte[3:0];

    // Decimal accumulate steps
    assign code_prod = {4'd0, r_code} * 14'd10 + {10'd0, digit_val};
    assign facc_prod = {3'd0, r_facc} * 12'd10 + {8'd0, digit_val};

    // Field completion inside the tuple
    always_comb begin
        do_complete = 1'b0;
        if (r_inside && !is_digit) begin
            if (i_byte == fprp_pkg::CHAR_COMMA && r_idx < fprp_pkg::LAST_FIELD) begin
                do_complete = 1'b1;
            end else if (i_byte == fprp_pkg::CHAR_RPAREN && r_idx == fprp_pkg::LAST_FIELD) begin
                do_complete = 1'b1;
            end
        end
    end

    // Close an unfinished sixth field at the newline
    assign close_last = r_inside && (r_idx == fprp_pkg::LAST_FIELD);
    assign last_field = close_last ? r_facc[7:0] : r_fields[fprp_pkg::NUM_FIELDS-1];
    assign ovf_end    = r_ovf || (close_last && r_facc[8]);
    assign tuple_ok   = (close_last || r_idx == fprp_pkg::ALL_FIELDS) && !ovf_end;

    // Build the result of a final line
    always_comb begin
        o_result.reply_code    = r_code;
        o_result.command_error = (r_code == fprp_pkg::CODE_FILE_ERR) ||
                                 (r_code == fprp_pkg::CODE_LOGIN_ERR);
        o_result.tuple_valid   = tuple_ok;
        if (tuple_ok) begin
            o_result.server_address = {r_fields[0], r_fields[1], r_fields[2], r_fields[3]};
            o_result.data_port      = {r_fields[4], last_field};
        end else begin
            o_result.server_address = '0;
            o_result.data_port      = '0;
        end
    end

    // Hold a result byte only while the output slot is busy
    assign is_result = is_lf && r_final;
    assign o_take    = i_valid && (!is_result || i_slot_free);
    assign o_load    = o_take && is_result;

    // Next line state
    always_comb begin
        n_pos       = r_pos;
        n_final     = r_final;
        n_code      = r_code;
        n_code_done = r_code_done;
        n_inside    = r_inside;
        n_idx       = r_idx;
        n_facc      = r_facc;
        n_ovf       = r_ovf;
        for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) begin
            n_fields[i] = r_fields[i];
        end

        if (is_lf) begin
            n_pos       = '0;
            n_final     = 1'b0;
            n_code      = '0;
            n_code_done = 1'b0;
            n_inside    = 1'b0;
            n_idx       = '0;
            n_facc      = '0;
            n_ovf       = 1'b0;
            for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) begin
                n_fields[i] = '0;
            end
        end else if (!is_cr) begin
            // leading reply code digits
            if (!r_code_done) begin
                if (is_digit) begin
                    n_code = (code_prod > {4'd0, fprp_pkg::CODE_MAX}) ?
                             fprp_pkg::CODE_MAX : code_prod[9:0];
                end else begin
                    n_code_done = 1'b1;
                end
            end

            // final line when the fourth character is a space
            if (r_pos == fprp_pkg::POS_FINAL && i_byte == fprp_pkg::CHAR_SPACE) begin
                n_final = 1'b1;
            end
            if (r_pos < fprp_pkg::POS_SAT) begin
                n_pos = r_pos + 3'd1;
            end

            // passive tuple fields
            priority if (r_inside && is_digit) begin
                n_facc = (facc_prod > {3'd0, fprp_pkg::FIELD_SAT}) ?
                         fprp_pkg::FIELD_SAT : facc_prod[8:0];
            end else if (do_complete) begin
                if (r_facc[8]) begin
                    n_ovf = 1'b1;
                end
                for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) begin
                    if (r_idx == 3'(i)) begin
                        n_fields[i] = r_facc[7:0];
                    end
                end
                n_idx  = r_idx + 3'd1;
                n_facc = '0;
                if (r_idx == fprp_pkg::LAST_FIELD) begin
                    n_inside = 1'b0;
                end
            end else if (!r_inside && i_byte == fprp_pkg::CHAR_LPAREN && r_idx == '0) begin
                n_inside = 1'b1;
                n_facc   = '0;
            end else begin
                n_inside = r_inside;
            end
        end
    end

    // Advance the line state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_final     <= 1'b0;
            r_code      <= '0;
            r_code_done <= 1'b0;
            r_inside    <= 1'b0;
            r_idx       <= '0;
            r_facc      <= '0;
            r_ovf       <= 1'b0;
            for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) begin
                r_fields[i] <= '0;
            end
        end else if (o_take) begin
            r_pos       <= n_pos;
            r_final     <= n_final;
            r_code      <= n_code;
            r_code_done <= n_code_done;
            r_inside    <= n_inside;
            r_idx       <= n_idx;
            r_facc      <= n_facc;
            r_ovf       <= n_ovf;
            for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) begin
                r_fields[i] <= n_fields[i];
            end
        end
    end

endmodule

>>> src/fprp_out_reg.sv
`timescale 1ns / 1ps

module fprp_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  fprp_pkg::t_result                   i_result,
    output logic                                o_slot_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fprp_pkg::OUT_TDATA_W-1:0]    o_data,
    output fprp_pkg::t_result                   o_result
);

    localparam int unsigned RES_W = $bits(fprp_pkg::t_result);

    logic              r_valid;
    fprp_pkg::t_result r_result;

    // Slot frees when empty or when the held result transfers now
    assign o_slot_free = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_result    = r_result;
    assign o_data      = {{(fprp_pkg::OUT_TDATA_W - RES_W){1'b0}}, r_result};

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture a new result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> src/ftp_reply_pasv_parser.sv
`timescale 1ns / 1ps
//  Channel   Dir  Handshake               Payload
//  s         in   i_s_tvalid/o_s_tready   i_s_tdata[7:0] rx_byte
//  m         out  o_m_tvalid/i_m_tready   o_m_tdata reply result, 60 bits in 64
//
//  One byte per cycle while no newline is held back; a newline ending a final
//  reply line leaves a result in the output register.
//  The byte path is input register -> line state update -> output register.
//  A stalled output holds back only a result-making newline; other bytes
//  keep flowing. Synchronous active-low reset clears all line state.

module ftp_reply_pasv_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fprp_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [7:0] rx_byte
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [9:0] reply_code, [10] command_error, [11] tuple_valid,
    // [43:12] server_address, [59:44] data_port, [63:60] zero
    output logic [fprp_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic              w_byte_valid;
    logic [7:0]        w_byte;
    logic              w_take;
    logic              w_load;
    logic              w_slot_free;
    fprp_pkg::t_result w_result;
    fprp_pkg::t_result w_out_result;

    fprp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .o_valid (w_byte_valid),
        .o_byte  (w_byte),
        .i_take  (w_take)
    );

    fprp_line_state u_line_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_byte_valid),
        .i_byte      (w_byte),
        .i_slot_free (w_slot_free),
        .o_take      (w_take),
        .o_load      (w_load),
        .o_result    (w_result)
    );

    fprp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_result    (w_result),
        .o_slot_free (w_slot_free),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_result    (w_out_result)
    );

    // No result may overwrite one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_slot_free |-> !w_load)
        else $error("result loaded into a busy output slot");

    // A loaded result shows on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // Invalid tuple carries zero address and port
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !w_out_result.tuple_valid) |->
        (w_out_result.server_address == '0 && w_out_result.data_port == '0))
        else $error("invalid tuple with nonzero address or port");

    // Error flag follows the reply code
    a_err_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out_result.command_error ==
        (w_out_result.reply_code == fprp_pkg::CODE_FILE_ERR ||
         w_out_result.reply_code == fprp_pkg::CODE_LOGIN_ERR)))
        else $error("command error flag does not match reply code");

    // Reply code stays saturated
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out_result.reply_code <= fprp_pkg::CODE_MAX))
        else $error("reply code above saturation limit");

endmodule

>>> verif/tb_ftp_reply_pasv_parser.sv
`timescale 1ns / 1ps

module tb_ftp_reply_pasv_parser;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BYTES  = 290;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [fprp_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;   // [7:0] rx_byte
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    // [9:0] reply_code, [10] command_error, [11] tuple_valid,
    // [43:12] server_address, [59:44] data_port, [63:60] zero
    logic [fprp_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    ftp_reply_pasv_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idling controls, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int cycle_count    = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int replies_seen   = 0;
    int valid_tuples   = 0;

    fprp_pkg::t_result expected_replies[$];

    // Line state mirrored from the parser
    logic [2:0] line_pos;
    logic       final_line;
    logic [9:0] code_acc;
    logic       code_done;
    logic       in_tuple;
    logic [2:0] fld_idx;
    logic [8:0] fld_acc;
    logic [7:0] tuple_bytes [fprp_pkg::NUM_FIELDS];
    logic       fld_ovf;

    task automatic clear_line_state();
        line_pos   = '0;
        final_line = 1'b0;
        code_acc   = '0;
        code_done  = 1'b0;
        in_tuple   = 1'b0;
        fld_idx    = '0;
        fld_acc    = '0;
        fld_ovf    = 1'b0;
        for (int i = 0; i < fprp_pkg::NUM_FIELDS; i++) tuple_bytes[i] = '0;
    endtask

    task automatic close_field();
        if (fld_idx < fprp_pkg::ALL_FIELDS) begin
            if (fld_acc > 9'd255) fld_ovf = 1'b1;
            tuple_bytes[fld_idx] = fld_acc[7:0];
            fld_idx = fld_idx + 3'd1;
        end
        fld_acc = '0;
        if (fld_idx >= fprp_pkg::ALL_FIELDS) in_tuple = 1'b0;
    endtask

    // Advance the line state by one received byte; queue a reply at a final newline
    task automatic predict_byte(input logic [7:0] c);
        fprp_pkg::t_result r;
        int                acc;
        logic              is_digit;
        is_digit = (c >= fprp_pkg::CHAR_ZERO) && (c <= fprp_pkg::CHAR_NINE);
        if (c == fprp_pkg::CHAR_CR) return;
        if (c == fprp_pkg::CHAR_LF) begin
            if (in_tuple && fld_idx == fprp_pkg::LAST_FIELD) close_field();
            if (final_line) begin
                r = '0;
                r.reply_code    = code_acc;
                r.command_error = (code_acc == fprp_pkg::CODE_FILE_ERR) ||
                                  (code_acc == fprp_pkg::CODE_LOGIN_ERR);
                r.tuple_valid   = (fld_idx == fprp_pkg::ALL_FIELDS) && !fld_ovf;
                if (r.tuple_valid) begin
                    r.server_address = {tuple_bytes[0], tuple_bytes[1],
                                        tuple_bytes[2], tuple_bytes[3]};
                    r.data_port      = {tuple_bytes[4], tuple_bytes[5]};
                end
                expected_replies.push_back(r);
            end
            clear_line_state();
            return;
        end
        // leading reply digits
        if (!code_done) begin
            if (is_digit) begin
                acc = int'(code_acc) * 10 + int'(c - fprp_pkg::CHAR_ZERO);
                code_acc = (acc > int'(fprp_pkg::CODE_MAX)) ? fprp_pkg::CODE_MAX : acc[9:0];
            end else begin
                code_done = 1'b1;
            end
        end
        // fourth character decides the final line
        if (line_pos == fprp_pkg::POS_FINAL && c == fprp_pkg::CHAR_SPACE) final_line = 1'b1;
        if (line_pos < fprp_pkg::POS_SAT) line_pos = line_pos + 3'd1;
        // passive tuple fields
        if (in_tuple) begin
            if (is_digit) begin
                acc = int'(fld_acc) * 10 + int'(c - fprp_pkg::CHAR_ZERO);
                fld_acc = (acc > int'(fprp_pkg::FIELD_SAT)) ? fprp_pkg::FIELD_SAT : acc[8:0];
            end else if (c == fprp_pkg::CHAR_COMMA && fld_idx < fprp_pkg::LAST_FIELD) begin
                close_field();
            end else if (c == fprp_pkg::CHAR_RPAREN && fld_idx == fprp_pkg::LAST_FIELD) begin
                close_field();
            end
        end else if (c == fprp_pkg::CHAR_LPAREN && fld_idx == 3'd0) begin
            in_tuple = 1'b1;
            fld_acc  = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Check outputs, then predict from the input transfer at the same edge
    always @(posedge i_clk) begin
        fprp_pkg::t_result got;
        fprp_pkg::t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[$bits(fprp_pkg::t_result)-1:0];
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected reply: expected none, actual 0x%0h",
                             $time, o_m_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    if (want.tuple_valid) valid_tuples++;
                    check_field("reply_code", 32'(want.reply_code), 32'(got.reply_code));
                    check_field("command_error", 32'(want.command_error),
                                32'(got.command_error));
                    check_field("tuple_valid", 32'(want.tuple_valid), 32'(got.tuple_valid));
                    check_field("server_address", want.server_address, got.server_address);
                    check_field("data_port", 32'(want.data_port), 32'(got.data_port));
                end
            end
            if (i_s_tvalid && o_s_tready) predict_byte(i_s_tdata);
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Hold the sender idle until every queued reply has come out
    task automatic drain_replies();
        i_s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One random reply line: mostly well-formed with random content, some noise
    task automatic send_random_line();
        int r;
        int code;
        int nf;
        int v;
        r = $urandom_range(99);
        if (r < 22) begin
            // raw noise over the whole byte range
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(255)));
            send_byte(fprp_pkg::CHAR_LF);
            return;
        end
        r = $urandom_range(99);
        if (r < 15)      code = 550;
        else if (r < 25) code = 530;
        else if (r < 55) code = 227;
        else if (r < 62) code = $urandom_range(99);
        else if (r < 66) code = $urandom_range(99999, 1000);
        else             code = $urandom_range(999);
        send_text($sformatf("%0d", code));
        send_byte(($urandom_range(99) < 80) ? fprp_pkg::CHAR_SPACE : "-");
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(99) < 75) begin
            send_text(" (");
            r = $urandom_range(99);
            nf = (r < 80) ? 6 : $urandom_range(1, 8);
            for (int f = 0; f < nf; f++) begin
                if ($urandom_range(99) < 15) send_byte(fprp_pkg::CHAR_SPACE);
                r = $urandom_range(99);
                if (r < 6)       v = -1;
                else if (r < 14) v = $urandom_range(99999, 256);
                else             v = $urandom_range(255);
                if (v >= 0) send_text($sformatf("%0d", v));
                if ($urandom_range(99) < 4) send_byte("x");
                if (f < nf - 1) send_byte(fprp_pkg::CHAR_COMMA);
            end
            if ($urandom_range(9) != 0) send_byte(fprp_pkg::CHAR_RPAREN);
            if ($urandom_range(99) < 15) send_text(" (9,8,7,6,5,4)");
            if ($urandom_range(99) < 30) send_byte(".");
        end
        if ($urandom_range(99) < 50) send_byte(fprp_pkg::CHAR_CR);
        send_byte(fprp_pkg::CHAR_LF);
    endtask

    task automatic run_random_lines(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_random_line();
        drain_replies();
    endtask

    // Reply codes, error flags, final versus continuation lines, stray bytes
    task automatic test_reply_codes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_text("550 \r\n");
        send_text("530 x\n");
        send_text("150-a\n");
        send_text("12345\n");
        send_text("ab c\n");
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(fprp_pkg::CHAR_SPACE);
        send_byte(8'hFF); send_byte(fprp_pkg::CHAR_LF);
        send_text("\n");
        send_text("2\r00 ok\n");
        drain_replies();
    endtask

    // Passive tuples: extremes, overflow, missing, unclosed, ignored delimiters
    task automatic test_passive_tuples();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_text("227 (255,255,255,255,255,255)\n");
        send_text("227 (0,0,0,0,0,0)\n");
        send_text("227 (1,2,3,4,5,256)\n");
        send_text("227 (1000,1,1,1,1,1)\n");
        send_text("227 (1,2,3,4)\n");
        send_text("227 (10, 20 ,30,40,5,6\n");
        send_text("227 (1),2,3,4,5,6,7)\n");
        send_text("227 (1,2,3,4,5,6) (7,7,7,7,7,7)\n");
        send_text("227 (,,,,,)\n");
        drain_replies();
    endtask

    task automatic test_stream_no_idling();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_lines(PHASE_BYTES);
    endtask

    task automatic test_stream_sender_gaps();
        src_idle_pct   = 68;
        sink_stall_pct = 0;
        run_random_lines(PHASE_BYTES);
    endtask

    task automatic test_stream_receiver_stalls();
        src_idle_pct   = 0;
        sink_stall_pct = 68;
        run_random_lines(PHASE_BYTES);
    endtask

    task automatic test_stream_both_idle();
        src_idle_pct   = 23;
        sink_stall_pct = 23;
        run_random_lines(PHASE_BYTES);
    endtask

    initial begin
        clear_line_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reply_codes();
        test_passive_tuples();
        test_stream_no_idling();
        test_stream_sender_gaps();
        test_stream_receiver_stalls();
        test_stream_both_idle();

        // let any stray reply surface
        sink_stall_pct = 0;
        repeat (20) @(posedge i_clk);

        $display("Sent %0d control bytes across four idling phases; %0d replies checked",
                 bytes_sent, replies_seen);
        $display("%0d replies carried a valid passive tuple, %0d mismatches",
                 valid_tuples, error_count);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
